>>> rtl/pgt_pkg.sv
package pgt_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] SLOT_NONE         = 8'd255;
  localparam logic [7:0] GROUPING_DIST_RST = 8'd15;
  localparam logic [7:0] DIST_FAR          = 8'd255;
  localparam logic [7:0] DIST_NEAR         = 8'd0;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic       is_tick;
    logic       in_group;
    logic [7:0] distance;
    logic [7:0] heard;
    logic [7:0] slot;
  } item_t;

endpackage

>>> rtl/pgt_front.sv
module pgt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,
  input  logic [23:0]         in_tdata,
  input  logic                q_full,
  output logic                q_push,
  output pgt_pkg::item_t      q_item
);
  import pgt_pkg::*;

  logic [7:0]        grouping_dist_r;
  logic [7:0]        grouping_dist_nxt;
  logic signed [7:0] snr;
  logic signed [8:0] k_wide;
  logic [10:0]       scaled;
  logic [10:0]       diff;
  logic [7:0]        distance;

  assign cfg_ready = 1'b1;

  always_comb begin
    grouping_dist_nxt = grouping_dist_r;
    if (cfg_valid) begin
      grouping_dist_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grouping_dist_r <= GROUPING_DIST_RST;
    end else begin
      grouping_dist_r <= grouping_dist_nxt;
    end
  end

  // Distance is (2044 - 17*(s+80)) / 8 inside the linear range; the
  // difference never goes negative there, so the floor is a plain shift.
  always_comb begin
    snr    = $signed(in_tdata[7:0]);
    k_wide = $signed({snr[7], snr}) + 9'sd80;
    scaled = {k_wide[6:0], 4'b0000} + {4'b0000, k_wide[6:0]};
    diff   = 11'd2044 - scaled;
    if (snr <= -8'sd80) begin
      distance = DIST_FAR;
    end else if (snr >= 8'sd40) begin
      distance = DIST_NEAR;
    end else begin
      distance = diff[10:3];
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_item.is_tick  = in_tuser;
    q_item.in_group = (distance <= grouping_dist_r);
    q_item.distance = distance;
    q_item.heard    = in_tdata[15:8];
    q_item.slot     = in_tdata[23:16];
  end

endmodule

>>> rtl/pgt_queue.sv
module pgt_queue #(
  parameter int unsigned DEPTH = pgt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pgt_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output pgt_pkg::item_t head_item
);
  import pgt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign avail     = (count_r != '0);
  assign head_item = entries[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_pop_moves_head: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not drop on pop");

  a_push_moves_tail: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not rise on push");

endmodule

>>> rtl/pgt_back.sv
module pgt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_avail,
  input  pgt_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [39:0]    out_tdata
);
  import pgt_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] member_count_r, member_count_nxt;
  logic [7:0] largest_heard_r, largest_heard_nxt;
  logic [7:0] cyc_slot_r, cyc_slot_nxt;
  logic [7:0] cyc_dist_r, cyc_dist_nxt;
  logic [7:0] pub_size_r, pub_size_nxt;
  logic [7:0] smoothed_r, smoothed_nxt;
  logic [7:0] pub_slot_r, pub_slot_nxt;
  logic [8:0] pub_delta_r, pub_delta_nxt;
  logic       largest_flag_r, largest_flag_nxt;
  logic [9:0] blend_sum;
  logic [7:0] blend;

  // A cycle-end item waits until the published result has been taken.
  assign q_pop = q_avail && (!q_item.is_tick || !out_valid_r || out_tready);

  assign blend_sum = {2'b00, smoothed_r} + {1'b0, cyc_dist_r, 1'b0}
                   + {2'b00, cyc_dist_r} + 10'd2;
  assign blend     = blend_sum[9:2];

  always_comb begin
    out_valid_nxt     = out_valid_r && !out_tready;
    member_count_nxt  = member_count_r;
    largest_heard_nxt = largest_heard_r;
    cyc_slot_nxt      = cyc_slot_r;
    cyc_dist_nxt      = cyc_dist_r;
    pub_size_nxt      = pub_size_r;
    smoothed_nxt      = smoothed_r;
    pub_slot_nxt      = pub_slot_r;
    pub_delta_nxt     = pub_delta_r;
    largest_flag_nxt  = largest_flag_r;
    if (q_pop) begin
      if (!q_item.is_tick) begin
        if (q_item.in_group) begin
          if (member_count_r != 8'd255) begin
            member_count_nxt = member_count_r + 1'b1;
          end
          if (q_item.heard > largest_heard_r) begin
            largest_heard_nxt = q_item.heard;
          end
        end else if (cyc_slot_r == SLOT_NONE ||
                     (q_item.distance < cyc_dist_r && q_item.heard >= pub_size_r)) begin
          cyc_dist_nxt = q_item.distance;
          cyc_slot_nxt = q_item.slot;
        end
      end else begin
        if (pub_slot_r != SLOT_NONE && cyc_slot_r != SLOT_NONE) begin
          smoothed_nxt  = blend;
          pub_delta_nxt = {1'b0, blend} - {1'b0, smoothed_r};
        end else if (cyc_slot_r != SLOT_NONE) begin
          smoothed_nxt  = cyc_dist_r;
          pub_delta_nxt = '0;
        end
        largest_flag_nxt  = (cyc_slot_r == SLOT_NONE);
        pub_size_nxt      = (member_count_r > largest_heard_r) ? member_count_r
                                                               : largest_heard_r;
        pub_slot_nxt      = cyc_slot_r;
        member_count_nxt  = 8'd1;
        largest_heard_nxt = 8'd0;
        cyc_dist_nxt      = DIST_FAR;
        cyc_slot_nxt      = SLOT_NONE;
        out_valid_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      member_count_r  <= 8'd1;
      largest_heard_r <= 8'd0;
      cyc_slot_r      <= SLOT_NONE;
      cyc_dist_r      <= 8'd0;
      pub_size_r      <= 8'd1;
      smoothed_r      <= 8'd255;
      pub_slot_r      <= SLOT_NONE;
      pub_delta_r     <= 9'd0;
      largest_flag_r  <= 1'b0;
    end else begin
      out_valid_r     <= out_valid_nxt;
      member_count_r  <= member_count_nxt;
      largest_heard_r <= largest_heard_nxt;
      cyc_slot_r      <= cyc_slot_nxt;
      cyc_dist_r      <= cyc_dist_nxt;
      pub_size_r      <= pub_size_nxt;
      smoothed_r      <= smoothed_nxt;
      pub_slot_r      <= pub_slot_nxt;
      pub_delta_r     <= pub_delta_nxt;
      largest_flag_r  <= largest_flag_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, largest_flag_r, pub_slot_r, pub_delta_r,
                       smoothed_r, pub_size_r};

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    member_count_r != 8'd0)
    else $error("member count reached zero");

  a_flag_matches_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (largest_flag_r == (pub_slot_r == SLOT_NONE)))
    else $error("largest-group flag disagrees with published slot");

  a_tick_clears_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.is_tick |=> member_count_r == 8'd1 && cyc_slot_r == SLOT_NONE
      && out_valid_r)
    else $error("cycle end did not clear counters and publish");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(pub_size_r) && $stable(smoothed_r))
    else $error("pending result overwritten");

endmodule

>>> rtl/proximity_group_tracker_core.sv
// Proximity group tracker core.
// The input channel (in_*) carries one beat per event: in_tuser low marks a
// heard packet, in_tuser high marks the end of a listening cycle. Packets
// produce no result; each cycle-end beat produces exactly one result beat on
// the out_* channel with the published group size, smoothed nearest distance,
// its change, the nearest slot and the largest-group flag.
// The cfg_* channel writes the grouping distance; it is always ready and
// should only be written while no beat is in flight.
// A front part maps SNR to distance and classifies each beat against the
// grouping distance, then pushes it into a small queue (QUEUE_DEPTH entries).
// The back part pops one beat per cycle, holding a cycle-end beat while a
// result is still untaken, and updates the per-cycle state. Throughput is
// one beat per clock while the queue is not full. A cycle-end beat is queued,
// then popped into the result register that drives out_tvalid.
// When the receiver stalls, the result stays on out_tdata and packet beats
// keep draining; the next cycle-end beat waits at the queue head, and once
// the queue fills, in_tready drops.
// Reset (rst_n low, synchronous) empties the queue, drops out_tvalid, restores
// the grouping distance to 15 and all tracking state to its initial values.
module proximity_group_tracker_core #(
  parameter int unsigned QUEUE_DEPTH = pgt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // grouping_distance
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,     // operation
  input  logic [23:0] in_tdata,     // snr_quarter_db, heard_group_size, sender_slot
  output logic        out_tvalid,
  input  logic        out_tready,
  // group_size[7:0], nearest_distance[15:8], distance_delta[24:16],
  // nearest_slot[32:25], in_largest_group[33], zero fill above
  output logic [39:0] out_tdata
);
  import pgt_pkg::*;

  item_t push_item;
  item_t head_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_avail;

  // Front: configuration register, distance mapping and classification.
  pgt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // Decoupling queue so either side can stall independently.
  pgt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head_item (head_item)
  );

  // Back: per-cycle tracking, smoothing and the published result register.
  pgt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_avail    (q_avail),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/proximity_group_tracker_core_tb.sv
module proximity_group_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pgt_pkg::*;

  // The single input field that selects what a beat means, carried on in_tuser.
  typedef enum logic {
    OP_PACKET    = 1'b0,
    OP_CYCLE_END = 1'b1
  } op_e;

  // One published report, laid out exactly as out_tdata[33:0] (lowest field last here).
  typedef struct packed {
    logic       largest;
    logic [7:0] slot;
    logic [8:0] delta;
    logic [7:0] distance;
    logic [7:0] size;
  } report_t;

  // One row of the directed table. When has_lit is set, the report is typed in by hand.
  typedef struct packed {
    op_e        op;
    logic [7:0] snr;
    logic [7:0] heard;
    logic [7:0] slot;
    logic       has_lit;
    report_t    lit;
  } plan_row_t;

  localparam int PLAN_ROWS      = 19;
  localparam int STALL_LIMIT    = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 250;
  localparam int NUM_PHASES     = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = 1'b0;       // operation
  logic [23:0] in_tdata = 24'd0;      // snr_quarter_db, heard_group_size, sender_slot
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // group_size, nearest_distance, distance_delta, nearest_slot, in_largest_group
  logic [39:0] out_tdata;

  proximity_group_tracker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reports that the tracker owes us, oldest first.
  report_t   pending_reports[$];
  int        error_count = 0;
  // While quiet is set, neither side inserts any idle cycles.
  bit        quiet = 1'b0;
  plan_row_t plan[PLAN_ROWS];

  // The tracker's state as we believe it to be.
  logic [7:0] trk_grouping;
  logic [7:0] trk_members;
  logic [7:0] trk_top_heard;
  logic [7:0] trk_near_slot;
  logic [7:0] trk_near_dist;
  logic [7:0] trk_size;
  logic [7:0] trk_smoothed;
  logic [7:0] trk_slot;
  logic [8:0] trk_delta;
  logic       trk_largest;

  task automatic tracker_reset();
    trk_grouping  = GROUPING_DIST_RST;
    trk_members   = 8'd1;
    trk_top_heard = 8'd0;
    trk_near_slot = SLOT_NONE;
    trk_near_dist = 8'd0;
    trk_size      = 8'd1;
    trk_smoothed  = DIST_FAR;
    trk_slot      = SLOT_NONE;
    trk_delta     = 9'd0;
    trk_largest   = 1'b0;
  endtask

  // SNR in quarter dB to a distance: far at or below -20 dB, zero at or above 10 dB, linear between.
  function automatic logic [7:0] snr_distance(logic signed [7:0] snr);
    int k;
    if (snr <= -80) return DIST_FAR;
    if (snr >= 40) return DIST_NEAR;
    k = int'(snr) + 80;
    return 8'((2044 - 17 * k) / 8);
  endfunction

  // Applies one accepted beat to the tracker state; a cycle end yields one report.
  task automatic tracker_step(input op_e op, input logic [7:0] snr, input logic [7:0] heard,
                              input logic [7:0] slot, output bit produced,
                              output report_t rep);
    logic [7:0] distance;
    int         blended;
    produced = 1'b0;
    rep = '0;
    if (op == OP_PACKET) begin
      distance = snr_distance(snr);
      if (distance <= trk_grouping) begin
        if (trk_members != 8'd255) trk_members = trk_members + 8'd1;
        if (heard > trk_top_heard) trk_top_heard = heard;
      end else if (trk_near_slot == SLOT_NONE ||
                   (distance < trk_near_dist && heard >= trk_size)) begin
        trk_near_dist = distance;
        trk_near_slot = slot;
      end
    end else begin
      if (trk_slot != SLOT_NONE && trk_near_slot != SLOT_NONE) begin
        // Both cycles saw a neighbor: blend one part old with three parts new.
        blended      = (int'(trk_smoothed) + 3 * int'(trk_near_dist) + 2) / 4;
        trk_delta    = 9'(blended - int'(trk_smoothed));
        trk_smoothed = 8'(blended);
      end else if (trk_near_slot != SLOT_NONE) begin
        trk_smoothed = trk_near_dist;
        trk_delta    = 9'd0;
      end
      trk_largest   = (trk_near_slot == SLOT_NONE);
      trk_size      = (trk_members > trk_top_heard) ? trk_members : trk_top_heard;
      trk_slot      = trk_near_slot;
      trk_members   = 8'd1;
      trk_top_heard = 8'd0;
      trk_near_dist = DIST_FAR;
      trk_near_slot = SLOT_NONE;
      produced      = 1'b1;
      rep           = '{largest: trk_largest, slot: trk_slot, delta: trk_delta,
                        distance: trk_smoothed, size: trk_size};
    end
  endtask

  // Most gaps are short, a few are long, and quiet stretches have none at all.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Presents one beat, waits for the handshake, then records what it should cause.
  task automatic send_beat(input op_e op, input logic [7:0] snr, input logic [7:0] heard,
                           input logic [7:0] slot, input bit use_lit, input report_t lit);
    bit      produced;
    report_t rep;
    int      gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {slot, heard, snr};
    do @(posedge clk); while (!in_tready);
    tracker_step(op, snr, heard, slot, produced, rep);
    if (produced) pending_reports.push_back(use_lit ? lit : rep);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed report has come out. Packet beats leave no
  // report behind, so a few more cycles let any of them still in the queue drain.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grouping(input logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trk_grouping = value;
  endtask

  // A random packet. Announced sizes cluster around the last published size so that
  // the "no smaller group" rule for the nearest neighbor is exercised from both sides.
  task automatic send_random_packet();
    logic [7:0] snr;
    logic [7:0] heard;
    logic [7:0] slot;
    int         h;
    snr = (($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 118) - 79));
    if ($urandom_range(0, 1) == 0) begin
      heard = 8'($urandom_range(0, 255));
    end else begin
      h = int'(trk_size) + $urandom_range(0, 4) - 2;
      heard = (h < 0) ? 8'd0 : (h > 255) ? 8'd255 : 8'(h);
    end
    slot = ($urandom_range(0, 31) == 0) ? SLOT_NONE : 8'($urandom_range(0, 254));
    send_beat(OP_PACKET, snr, heard, slot, 1'b0, '0);
  endtask

  function automatic int cycle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 98) return $urandom_range(9, 30);
    return $urandom_range(31, 80);
  endfunction

  // The receiver stalls now and then, mostly briefly and occasionally for a long while.
  initial begin
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        end
      end
    end
  end

  // Every result beat is compared field by field with the oldest owed report.
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = report_t'(out_tdata[33:0]);
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("group_size", want.size, got.size);
        check_field("nearest_distance", want.distance, got.distance);
        check_field("distance_delta", want.delta, got.delta);
        check_field("nearest_slot", want.slot, got.slot);
        check_field("in_largest_group", want.largest, got.largest);
        check_field("tdata fill", 0, out_tdata[39:34]);
      end
    end
  end

  // The watchdog ends the run if no beat moves on any channel for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] settings[NUM_PHASES];
    int         phase_items;
    int         n;

    // Directed walk at the reset grouping distance of 15.
    // A cycle end straight after reset: alone, nothing heard, smoothing untouched.
    plan[0]  = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b1,
                 '{1'b1, 8'd255, 9'd0, 8'd255, 8'd1}};
    // Strongest SNR is distance zero and joins the group announcing the largest size.
    plan[1]  = '{OP_PACKET,    8'h7F,  8'd255, 8'd0,   1'b0, '0};
    // Weakest SNR is the farthest distance and becomes the first nearest neighbor.
    plan[2]  = '{OP_PACKET,    8'h80,  8'd0,   8'd254, 1'b0, '0};
    // First neighbor after none: the smoothed distance is taken as it is.
    plan[3]  = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b1,
                 '{1'b0, 8'd254, 9'd0, 8'd255, 8'd255}};
    // Exactly -20 dB is still the far end; -20 dB plus one step is the first ramp value.
    plan[4]  = '{OP_PACKET,    8'hB0,  8'd0,   8'd10,  1'b0, '0};
    plan[5]  = '{OP_PACKET,    8'd39,  8'd3,   8'd11,  1'b0, '0};
    plan[6]  = '{OP_PACKET,    8'hB1,  8'd255, 8'd20,  1'b0, '0};
    // Closer, but announcing a smaller group than ours: it must not take over.
    plan[7]  = '{OP_PACKET,    8'd0,   8'd254, 8'd30,  1'b0, '0};
    plan[8]  = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b0, '0};
    // A sender in the reserved slot is stored but reads as no neighbor at all.
    plan[9]  = '{OP_PACKET,    8'h80,  8'd9,   8'd255, 1'b0, '0};
    plan[10] = '{OP_PACKET,    8'hD8,  8'd9,   8'd40,  1'b0, '0};
    plan[11] = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b0, '0};
    plan[12] = '{OP_PACKET,    8'h9C,  8'd7,   8'd255, 1'b0, '0};
    plan[13] = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b0, '0};
    // Distance 15 sits on the group boundary; one step weaker lands outside it.
    plan[14] = '{OP_PACKET,    8'd33,  8'd4,   8'd1,   1'b0, '0};
    plan[15] = '{OP_PACKET,    8'd32,  8'd0,   8'd5,   1'b0, '0};
    plan[16] = '{OP_PACKET,    8'd31,  8'd200, 8'd6,   1'b0, '0};
    plan[17] = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b0, '0};
    // Empty cycle: distance and its change are held, the flag comes back.
    plan[18] = '{OP_CYCLE_END, 8'd0,   8'd0,   8'd0,   1'b0, '0};

    // Grouping distance per random phase, both extremes among them.
    settings[0] = 8'd0;
    settings[1] = 8'd255;
    settings[2] = 8'($urandom_range(16, 254));
    settings[3] = 8'($urandom_range(1, 14));
    settings[4] = GROUPING_DIST_RST;

    tracker_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_beat(plan[i].op, plan[i].snr, plan[i].heard, plan[i].slot,
                plan[i].has_lit, plan[i].lit);
    end

    // Random part: mostly whole listening cycles with random packets, phase by phase.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_grouping(settings[p]);
      quiet = (p == 3);
      phase_items = 0;
      if (settings[p] == 8'd255) begin
        // Everything is inside the group here, so a long cycle drives the member
        // count into saturation.
        for (int j = 0; j < 260; j++) send_random_packet();
        send_beat(OP_CYCLE_END, 8'd0, 8'd0, 8'd0, 1'b0, '0);
        phase_items += 261;
      end
      while (phase_items < PHASE_ITEMS) begin
        n = cycle_length();
        for (int j = 0; j < n; j++) send_random_packet();
        if ($urandom_range(0, 19) == 0) drain();
        send_beat(OP_CYCLE_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
        phase_items += n + 1;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pgt_pkg.sv
rtl/pgt_front.sv
rtl/pgt_queue.sv
rtl/pgt_back.sv
rtl/proximity_group_tracker_core.sv
tb/sv/proximity_group_tracker_core_tb.sv
